FILE: sv/m3inv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and constants of the 3x3 adjugate inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

    localparam int NUM_ELEM  = 9;
    localparam int ELEM_W    = 32;
    localparam int DET_W     = 64;
    // quotient bits kept: enough to tell any value that saturates
    localparam int DIV_STEPS = 33;
    localparam int NLO_W     = 16;

    localparam logic [31:0] THR_RESET = 32'd4295;

    typedef logic [NUM_ELEM-1:0][ELEM_W-1:0] t_mat;
    typedef logic [NUM_ELEM-1:0][DET_W-1:0]  t_cof;

    // one divider lane: partial remainder, unused dividend bits, quotient
    typedef struct packed {
        logic [63:0]          rem;
        logic [NLO_W-1:0]     nlo;
        logic [DIV_STEPS-1:0] quo;
    } t_dlane;

    typedef t_dlane [NUM_ELEM-1:0] t_lanes;

    // cofactor i = m[A]*m[B] - m[C]*m[D], negated for odd i
    typedef logic [3:0] t_idx;
    localparam t_idx CF_A [NUM_ELEM] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
    localparam t_idx CF_B [NUM_ELEM] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
    localparam t_idx CF_C [NUM_ELEM] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};
    localparam t_idx CF_D [NUM_ELEM] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};

endpackage
`default_nettype wire

FILE: sv/m3inv_divstep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3inv_divstep
// One restoring-division stage for all nine lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module m3inv_divstep #(
    parameter int STEP = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_ce,
    input  wire logic            i_vld,
    input  wire logic [63:0]     i_d,
    input  wire m3inv_pkg::t_lanes i_ln,
    output logic                 o_vld,
    output logic [63:0]          o_d,
    output m3inv_pkg::t_lanes    o_ln
);
    import m3inv_pkg::*;

    // dividend is n * 2^17; bit J of it is n[J-17], zero below
    localparam int  J    = DIV_STEPS - 1 - STEP;
    localparam logic USE = (J >= 17);
    localparam int  NIDX = (J >= 17) ? (J - 17) : 0;

    t_lanes n_ln;

    always_comb begin
        logic [64:0] rt;
        logic        b;
        for (int i = 0; i < NUM_ELEM; i++) begin
            b  = USE & i_ln[i].nlo[NIDX];
            rt = {i_ln[i].rem, b};
            n_ln[i] = i_ln[i];
            if (rt >= {1'b0, i_d}) begin
                n_ln[i].rem = 64'(rt - {1'b0, i_d});
                n_ln[i].quo = {i_ln[i].quo[DIV_STEPS-2:0], 1'b1};
            end else begin
                n_ln[i].rem = rt[63:0];
                n_ln[i].quo = {i_ln[i].quo[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_ce) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_d  <= i_d;
            o_ln <= n_ln;
        end
    end

endmodule
`default_nettype wire

FILE: sv/mat3_inverse_determinant.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mat3_inverse_determinant
// 3x3 Q16.16 matrix inverse by adjugate over determinant, with singular check.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s        in   i_s_tdata: nine Q16.16 elements, column-major
//  m        out  o_m_tdata: nine Q16.16 results, Q32.32 determinant; tuser: singular
//  cfg      in   i_cfg_wdata: singular threshold, Q0.32 magnitude
//
//  One transaction per clock unless the skid is full: nine arithmetic stages, then
//  a 33-stage restoring divider (one quotient bit per stage), then the
//  output register. A skid register lets one more item in while a result
//  waits; the pipeline then holds until it drains. Reset clears valids and
//  restores the default threshold.
// ----------------------------------------------------------------------------
module mat3_inverse_determinant (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // a_col0_row0 .. a_col2_row2, 32 bits each from bit 0
    input  wire logic [287:0]  i_s_tdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // r_col0_row0 .. r_col2_row2 (32 each), det_value [351:288]
    output logic [351:0]       o_m_tdata,
    // singular
    output logic [0:0]         o_m_tuser,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_wdata
);
    import m3inv_pkg::*;

    typedef struct packed {
        t_mat                mat;
        logic [63:0]         det;
        logic                sing;
        logic [NUM_ELEM-1:0] neg;
        logic [NUM_ELEM-1:0] ovf;
    } t_side;

    logic        r_skid_vld;
    logic [352:0] r_skid;
    logic        ce;
    logic [31:0] r_thr;

    logic [9:1]  r_vld;
    t_mat        r_am [1:7];
    logic signed [63:0] r_p [2*NUM_ELEM];
    t_cof        r_cm [3:7];
    logic signed [64:0] r_ml [3];
    logic signed [63:0] r_mh [3];
    logic signed [97:0] r_t  [3];
    logic signed [97:0] r_s01;
    logic signed [97:0] r_t2;
    logic [63:0] r_det;
    t_side       r_sd [0:DIV_STEPS+1];
    t_cof        r_n;
    logic [63:0] r_dm;
    logic [63:0] r_d9;
    t_lanes      r_ln9;

    logic        w_vld [0:DIV_STEPS];
    logic [63:0] w_d   [0:DIV_STEPS];
    t_lanes      w_ln  [0:DIV_STEPS];

    logic        take;
    logic [352:0] pdata;

    assign ce         = ~r_skid_vld;
    assign o_s_tready = ce;
    assign take       = o_m_tvalid & i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[8:1], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [97:0] sum;
        logic [81:0]        y;
        logic [63:0]        cm;
        logic [63:0]        dm;
        t_side              sd1;
        if (ce) begin
            // stage 1: capture
            r_am[1] <= i_s_tdata;
            for (int s = 2; s <= 7; s++) r_am[s] <= r_am[s-1];
            // stage 2: cofactor products
            for (int i = 0; i < NUM_ELEM; i++) begin
                r_p[2*i]   <= $signed(r_am[1][CF_A[i]]) * $signed(r_am[1][CF_B[i]]);
                r_p[2*i+1] <= $signed(r_am[1][CF_C[i]]) * $signed(r_am[1][CF_D[i]]);
            end
            // stage 3: cofactors, wrapping to 64 bits
            for (int i = 0; i < NUM_ELEM; i++) begin
                if (i % 2 == 1) r_cm[3][i] <= r_p[2*i+1] - r_p[2*i];
                else            r_cm[3][i] <= r_p[2*i] - r_p[2*i+1];
            end
            for (int s = 4; s <= 7; s++) r_cm[s] <= r_cm[s-1];
            // stage 4: first-row element times cofactor, split in halves
            for (int k = 0; k < 3; k++) begin
                r_ml[k] <= $signed(r_am[3][3*k]) * $signed({1'b0, r_cm[3][k][31:0]});
                r_mh[k] <= $signed(r_am[3][3*k]) * $signed(r_cm[3][k][63:32]);
            end
            // stage 5: exact terms
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= $signed({{2{r_mh[k][63]}}, r_mh[k], 32'b0})
                        + $signed({{33{r_ml[k][64]}}, r_ml[k]});
            end
            // stage 6
            r_s01 <= r_t[0] + r_t[1];
            r_t2  <= r_t[2];
            // stage 7: round half up to Q32.32, saturate
            sum = r_s01 + r_t2 + 98'sd32768;
            y   = sum[97:16];
            if ((&y[81:63]) || !(|y[81:63])) r_det <= y[63:0];
            else if (sum[97])                r_det <= {1'b1, 63'b0};
            else                             r_det <= {1'b0, {63{1'b1}}};
            // stage 8: magnitudes, signs, singular decision
            dm = r_det[63] ? 64'(-r_det) : r_det;
            r_dm <= dm;
            r_sd[0].mat  <= r_am[7];
            r_sd[0].det  <= r_det;
            r_sd[0].sing <= (r_det == 64'd0) || (dm < {32'b0, r_thr});
            r_sd[0].ovf  <= '0;
            for (int i = 0; i < NUM_ELEM; i++) begin
                cm = r_cm[7][i][63] ? 64'(-r_cm[7][i]) : r_cm[7][i];
                r_n[i] <= cm;
                r_sd[0].neg[i] <= (r_cm[7][i][63] != r_det[63]) && (r_cm[7][i] != 64'd0);
            end
            // stage 9: quotient overflow check, divider seed
            sd1 = r_sd[0];
            for (int i = 0; i < NUM_ELEM; i++) begin
                sd1.ovf[i]     = {16'b0, r_n[i]} >= {r_dm, 16'b0};
                r_ln9[i].rem   <= {16'b0, r_n[i][63:16]};
                r_ln9[i].nlo   <= r_n[i][15:0];
                r_ln9[i].quo   <= '0;
            end
            r_sd[1] <= sd1;
            r_d9 <= r_dm;
            for (int s = 2; s <= DIV_STEPS + 1; s++) r_sd[s] <= r_sd[s-1];
        end
    end

    assign w_vld[0] = r_vld[9];
    assign w_d[0]   = r_d9;
    assign w_ln[0]  = r_ln9;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        m3inv_divstep #(.STEP(g)) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (ce),
            .i_vld  (w_vld[g]),
            .i_d    (w_d[g]),
            .i_ln   (w_ln[g]),
            .o_vld  (w_vld[g+1]),
            .o_d    (w_d[g+1]),
            .o_ln   (w_ln[g+1])
        );
    end

    // final rounding (half away from zero), sign and saturation
    always_comb begin
        logic [33:0] inc;
        logic [32:0] r;
        logic        big;
        t_side       sd;
        sd = r_sd[DIV_STEPS+1];
        for (int i = 0; i < NUM_ELEM; i++) begin
            inc = {1'b0, w_ln[DIV_STEPS][i].quo} + 34'd1;
            r   = inc[33:1];
            big = sd.ovf[i] || (r[32:31] != 2'b00);
            if (sd.sing)     pdata[32*i +: 32] = sd.mat[i];
            else if (sd.neg[i]) pdata[32*i +: 32] = big ? 32'h8000_0000 : 32'(-r[31:0]);
            else             pdata[32*i +: 32] = big ? 32'h7FFF_FFFF : r[31:0];
        end
        pdata[351:288] = sd.det;
        pdata[352]     = sd.sing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                {o_m_tuser, o_m_tdata} <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (!o_m_tvalid || take) begin
            o_m_tvalid <= w_vld[DIV_STEPS];
            {o_m_tuser, o_m_tdata} <= pdata;
        end else if (w_vld[DIV_STEPS]) begin
            r_skid     <= pdata;
            r_skid_vld <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> o_m_tvalid) else $error("skid holds data with output empty");
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !take) |=> r_skid_vld) else $error("skid entry lost");
    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[DIV_STEPS] && !ce) |=> w_vld[DIV_STEPS]) else $error("stalled item lost");
    a_inv_det_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[351:288] != 64'd0))
        else $error("inverse issued for zero determinant");
`endif

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the 3x3 adjugate inverse: directed and random matrices under
// several singular thresholds, each result checked against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import m3inv_pkg::*;

    typedef struct packed {
        t_mat        elem;
        logic        singular;
        logic [63:0] det;
    } t_inv_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic [287:0] s_tdata;
    logic         m_tready;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    wire          s_tready;
    wire          m_tvalid;
    wire  [351:0] m_tdata;
    wire  [0:0]   m_tuser;

    t_inv_result  inverse_q[$];
    logic [31:0]  threshold;
    int           errors;
    bit           no_idle;
    int           ready_wait;

    mat3_inverse_determinant uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [63:0] magnitude(input longint v);
        logic [63:0] u;
        u = v;
        return v < 0 ? -u : u;
    endfunction

    // one inverse element: |cof|*2^16/|det| rounded half away, signed, saturated
    function automatic logic [31:0] inv_element(input longint cof, input longint det);
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] q;
        num = {64'd0, magnitude(cof)} << 17;
        quo = num / {64'd0, magnitude(det)};
        if (quo > (128'd1 << 40))
            quo = 128'd1 << 40;
        q = (quo + 1) >> 1;
        if ((cof < 0) != (det < 0) && cof != 0) begin
            if (q >= 128'h8000_0000)
                return 32'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic t_inv_result invert_matrix(input t_mat a);
        longint d [9];
        longint c [9];
        logic signed [127:0] acc;
        logic signed [127:0] shifted;
        longint det;
        t_inv_result r;
        for (int i = 0; i < 9; i++)
            d[i] = longint'($signed(a[i]));
        c[0] = d[4] * d[8] - d[5] * d[7];
        c[1] = -(d[1] * d[8] - d[2] * d[7]);
        c[2] = d[1] * d[5] - d[2] * d[4];
        c[3] = -(d[3] * d[8] - d[5] * d[6]);
        c[4] = d[0] * d[8] - d[2] * d[6];
        c[5] = -(d[0] * d[5] - d[2] * d[3]);
        c[6] = d[3] * d[7] - d[4] * d[6];
        c[7] = -(d[0] * d[7] - d[1] * d[6]);
        c[8] = d[0] * d[4] - d[1] * d[3];
        acc = 128'sd0;
        for (int i = 0; i < 3; i++)
            acc = acc + 128'(signed'(d[3 * i])) * 128'(signed'(c[i]));
        // Q48.48 to Q32.32, half up, then saturate
        acc = acc + 128'sh8000;
        shifted = acc >>> 16;
        if (shifted > 128'sh7FFF_FFFF_FFFF_FFFF)
            det = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (shifted < -128'sh8000_0000_0000_0000)
            det = 64'sh8000_0000_0000_0000;
        else
            det = shifted[63:0];
        r.det = det;
        r.singular = det == 0 || magnitude(det) < {32'd0, threshold};
        for (int i = 0; i < 9; i++)
            r.elem[i] = r.singular ? a[i] : inv_element(c[i], det);
        return r;
    endfunction

    // result side: random stalls, compare against oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            ready_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (inverse_q.size() == 0) begin
                    $error("result transaction with no matrix outstanding");
                    errors++;
                end else begin
                    t_inv_result exp_r;
                    exp_r = inverse_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_tdata[32 * i +: 32] !== exp_r.elem[i]) begin
                            $error("r_col%0d_row%0d expected %h actual %h", i / 3, i % 3,
                                   exp_r.elem[i], m_tdata[32 * i +: 32]);
                            errors++;
                        end
                    if (m_tdata[351:288] !== exp_r.det) begin
                        $error("det_value expected %h actual %h", exp_r.det, m_tdata[351:288]);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_r.singular) begin
                        $error("singular expected %b actual %b", exp_r.singular, m_tuser[0]);
                        errors++;
                    end
                end
                ready_wait = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (ready_wait > 0) begin
                m_tready <= 1'b0;
                ready_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_matrix(input t_mat a);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        inverse_q.push_back(invert_matrix(a));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (inverse_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        threshold = value;
    endtask

    function automatic t_mat diag(input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z);
        t_mat m;
        m = '0;
        m[0] = x;
        m[4] = y;
        m[8] = z;
        return m;
    endfunction

    function automatic t_mat random_matrix();
        t_mat m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0, 1: begin
                    m[i] = $urandom;
                end
                2, 3, 4: begin
                    m[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                end
                5, 6: begin
                    // near identity
                    m[i] = (i % 4 == 0 ? 32'h0001_0000 : 32'h0)
                           + $signed($urandom_range(0, 8191)) - 4096;
                end
                7: begin
                    m[i] = $signed($urandom_range(0, 1023)) - 512;
                end
                default: begin
                    m[i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
                end
            endcase
        end
        // near singular: third column close to the first
        if (kind == 8 || kind == 3)
            for (int i = 0; i < 3; i++)
                m[6 + i] = m[i] + $urandom_range(0, 3);
        return m;
    endfunction

    task automatic test_directed();
        t_mat m;
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix('0);
        m = {9{32'h7FFF_FFFF}};
        send_matrix(m);
        m = {9{32'h8000_0000}};
        send_matrix(m);
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(diag(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        // determinant exactly at and just under the threshold
        send_matrix(diag(32'd256, 32'd256, 32'd4295));
        send_matrix(diag(32'd256, 32'd256, 32'd4294));
        send_matrix(diag(32'd256, 32'd256, -32'sd4295));
        // large inverse elements, of both signs
        send_matrix(diag(32'd256, 32'd256, 32'd65536));
        send_matrix(diag(-32'sd256, 32'd256, 32'd65536));
        // half-unit determinants round up
        send_matrix(diag(32'd1, 32'd1, 32'd32768));
        send_matrix(diag(32'd1, 32'd1, -32'sd32768));
        send_matrix(diag(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000));
        m = '0;
        m[1] = 32'h0001_0000;
        m[3] = 32'h0001_0000;
        m[8] = 32'h0003_0000;
        send_matrix(m);
        for (int i = 0; i < 9; i++)
            m[i] = 32'h0001_0000 * (i + 1);
        send_matrix(m);
    endtask

    task automatic test_threshold_edges();
        write_threshold(32'd0);
        send_matrix(diag(32'd1, 32'd1, 32'd32768));
        send_matrix(diag(32'd1, 32'd1, -32'sd32768));
        send_matrix('0);
        write_threshold(32'hFFFF_FFFF);
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0000_FFFF));
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000));
    endtask

    task automatic test_random(input logic [31:0] thr, input int count, input bit burst);
        write_threshold(thr);
        no_idle = burst;
        for (int n = 0; n < count; n++)
            send_matrix(random_matrix());
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        threshold = THR_RESET;
        errors    = 0;
        no_idle   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_threshold_edges();
        test_random(THR_RESET, 500, 1'b0);
        test_random(32'd0, 350, 1'b0);
        test_random(32'hFFFF_FFFF, 300, 1'b0);
        test_random($urandom, 350, 1'b1);
        test_random($urandom_range(0, 1 << 20), 380, 1'b0);

        wait_drained();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: mat3_inverse_determinant.f
sv/m3inv_pkg.sv
sv/m3inv_divstep.sv
sv/mat3_inverse_determinant.sv
dv/tb_top.sv
